// ----- rtl/core/spc_pkg.sv -----
// shared types, constants and helpers of the sphere pair contact core
package spc_pkg;

	localparam int RAD_W       = 66;
	localparam int NORM_W      = 33;
	localparam int REM_W       = 35;
	localparam int QUO_W       = 31;
	localparam int SQRT_STAGES = 33;
	localparam int DIV_STAGES  = 31;
	localparam int U_SHIFT     = 30;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_OVERLAP  = 2'd1,
		ST_COHESIVE = 2'd2,
		ST_TOO_DEEP = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] center_a_x;
		logic signed [31:0] center_a_y;
		logic signed [31:0] center_a_z;
		logic signed [31:0] center_b_x;
		logic signed [31:0] center_b_y;
		logic signed [31:0] center_b_z;
		logic [30:0]        radius_a;
		logic [30:0]        radius_b;
		logic [30:0]        shell_a;
		logic [30:0]        shell_b;
	} pair_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] gap;
		logic signed [31:0] overlap_x;
		logic signed [31:0] overlap_y;
		logic signed [31:0] overlap_z;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [31:0] contact_z;
	} contact_t;

	// per-pair data that rides along the square root
	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0][31:0] dmag;
		logic [2:0]       dneg;
		logic [30:0]      ra;
		logic [31:0]      rsum;
		logic [31:0]      ssum;
	} side_t;

	typedef struct packed {
		logic [NORM_W-1:0] norm;
		side_t             side;
	} sqrt_out_t;

	typedef struct packed {
		logic [NORM_W-1:0] norm;
		status_t           status;
		logic [34:0]       gap;
		logic [32:0]       gmag;
		logic              gneg;
		logic [32:0]       tmag;
		logic              tneg;
		logic [2:0][31:0]  a;
		logic [2:0][31:0]  dmag;
		logic [2:0]        dneg;
	} gap_out_t;

	typedef struct packed {
		gap_out_t              g;
		logic [2:0][QUO_W-1:0] q;
	} div_out_t;

	// clamp a 36-bit two's complement value to 32 bits
	function automatic logic [31:0] sat32(input logic [35:0] v);
		logic [31:0] r;
		if (v[35:31] == {5{v[35]}}) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/sphere_pair_contact_core.sv -----
// sphere pair contact core: takes one pair beat per clock and returns one contact beat per pair.
// the pipeline is 74 register stages deep, plus one output register: 3 front stages (difference,
// squares, sum), 33 square-root stages (one root bit each), 4 gap stages, 31 divider stages (one
// quotient bit of the three direction lanes each) and 3 back stages (multiply, sign, offset and
// clamp). a pair is accepted every clock while the output side keeps up; the whole pipeline
// advances together, and a one-beat skid register behind the output register keeps pair_ready a
// plain flop so a stalled contact beat costs at most one more accepted pair before pair_ready
// drops. cohesion mode is a single register bit written through cfg_wen/cfg_wdata; the user
// must write it only while no pair is in flight, and the block itself does not enforce this.
module sphere_pair_contact_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic              cfg_wdata,
	input  logic              pair_valid,
	output logic              pair_ready,
	input  spc_pkg::pair_t    pair,
	output logic              contact_valid,
	input  logic              contact_ready,
	output spc_pkg::contact_t contact
);
	import spc_pkg::*;

	logic      cohesion_q;
	logic      en;

	logic      fr_v;
	logic [RAD_W-1:0] fr_rad;
	side_t     fr_side;
	logic      sq_v;
	sqrt_out_t sq_d;
	logic      gp_v;
	gap_out_t  gp_d;
	logic      dv_v;
	div_out_t  dv_d;
	logic      bk_v;
	contact_t  bk_d;

	logic      out_valid_q, skid_valid_q;
	contact_t  out_q, skid_q;
	logic      pop;

	// cohesion mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cohesion_q <= 1'b0;
		end else if (cfg_wen) begin
			cohesion_q <= cfg_wdata;
		end
	end

	// the pipeline only holds while the skid register is occupied
	assign en         = !skid_valid_q;
	assign pair_ready = en;

	spc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (pair_valid),
		.in_d     (pair),
		.out_v    (fr_v),
		.out_rad  (fr_rad),
		.out_side (fr_side)
	);

	spc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (fr_v),
		.in_rad  (fr_rad),
		.in_side (fr_side),
		.out_v   (sq_v),
		.out_d   (sq_d)
	);

	spc_gap u_gap (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cohesion (cohesion_q),
		.in_v     (sq_v),
		.in_d     (sq_d),
		.out_v    (gp_v),
		.out_d    (gp_d)
	);

	spc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (gp_v),
		.in_d   (gp_d),
		.out_v  (dv_v),
		.out_d  (dv_d)
	);

	spc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (dv_v),
		.in_d   (dv_d),
		.out_v  (bk_v),
		.out_d  (bk_d)
	);

	assign pop = out_valid_q && contact_ready;

	// output register with skid: a beat leaving the pipeline goes to the output register when
	// that is free or being drained, otherwise it parks in the skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (bk_v) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (bk_v) begin
			if (!out_valid_q || pop) begin
				out_q <= bk_d;
			end else begin
				skid_q <= bk_d;
			end
		end
	end

	assign contact_valid = out_valid_q;
	assign contact       = out_q;

`ifndef NO_ASSERTIONS
	// a beat can only be parked while the output register is full
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full with empty output register");

	// no-contact and too-deep results carry an all-zero payload
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		contact_valid && (contact.status == ST_NONE || contact.status == ST_TOO_DEEP)
		|-> contact.gap == '0 && contact.overlap_x == '0 && contact.overlap_y == '0 &&
		    contact.overlap_z == '0 && contact.contact_x == '0 && contact.contact_y == '0 &&
		    contact.contact_z == '0)
		else $error("non-zero payload on a result without contact");

	// a cohesive result needs cohesion mode and a positive gap
	a_cohesive_gap: assert property (@(posedge clk) disable iff (!arst_n)
		contact_valid && contact.status == ST_COHESIVE
		|-> cohesion_q && !contact.gap[31] && contact.gap != '0)
		else $error("cohesive result without cohesion mode or with non-positive gap");

	// an overlap result never shows a positive gap
	a_overlap_gap: assert property (@(posedge clk) disable iff (!arst_n)
		contact_valid && contact.status == ST_OVERLAP
		|-> contact.gap[31] || contact.gap == '0)
		else $error("overlap result with positive gap");
`endif

endmodule

// ----- rtl/core/spc_front.sv -----
// front stages: center differences, squares and the sum of squares
module spc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  spc_pkg::pair_t in_d,
	output logic          out_v,
	output logic [spc_pkg::RAD_W-1:0] out_rad,
	output spc_pkg::side_t out_side
);
	import spc_pkg::*;

	logic              v_s1, v_s2, v_s3;
	side_t             side_n, side_s1, side_s2, side_s3;
	logic [2:0][63:0]  sq_n, sq_s2;
	logic [RAD_W-1:0]  rad_s3;
	logic [2:0][31:0]  ca, cb;
	logic [2:0][32:0]  dd;

	always_comb begin
		ca[0] = in_d.center_a_x;
		ca[1] = in_d.center_a_y;
		ca[2] = in_d.center_a_z;
		cb[0] = in_d.center_b_x;
		cb[1] = in_d.center_b_y;
		cb[2] = in_d.center_b_z;
		for (int i = 0; i < 3; i++) begin
			dd[i]          = {cb[i][31], cb[i]} - {ca[i][31], ca[i]};
			side_n.a[i]    = ca[i];
			side_n.dneg[i] = dd[i][32];
			side_n.dmag[i] = dd[i][32] ? 32'(-dd[i]) : dd[i][31:0];
		end
		side_n.ra   = in_d.radius_a;
		side_n.rsum = {1'b0, in_d.radius_a} + {1'b0, in_d.radius_b};
		side_n.ssum = {1'b0, in_d.shell_a} + {1'b0, in_d.shell_b};
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_n[i] = {32'd0, side_s1.dmag[i]} * {32'd0, side_s1.dmag[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_n;
			sq_s2   <= sq_n;
			side_s2 <= side_s1;
			rad_s3  <= RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]);
			side_s3 <= side_s2;
		end
	end

	assign out_v    = v_s3;
	assign out_rad  = rad_s3;
	assign out_side = side_s3;

endmodule

// ----- rtl/core/spc_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module spc_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [spc_pkg::RAD_W-1:0] in_rad,
	input  spc_pkg::side_t    in_side,
	output logic              out_v,
	output spc_pkg::sqrt_out_t out_d
);
	import spc_pkg::*;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [NORM_W-1:0] root;
		side_t             side;
	} sq_stage_t;

	logic [SQRT_STAGES-1:0] v_s;
	sq_stage_t              stg_s [SQRT_STAGES];
	sq_stage_t              cur   [SQRT_STAGES];
	sq_stage_t              nxt   [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [REM_W+1:0] cand, trial;
		logic             ge;

		if (k == 0) begin : g_first
			always_comb begin
				cur[k].rad  = in_rad;
				cur[k].rem  = '0;
				cur[k].root = '0;
				cur[k].side = in_side;
			end
		end else begin : g_rest
			assign cur[k] = stg_s[k-1];
		end

		always_comb begin
			cand  = {cur[k].rem, cur[k].rad[RAD_W-1-2*k -: 2]};
			trial = {2'b00, cur[k].root, 2'b01};
			ge    = cand >= trial;
			nxt[k].rad  = cur[k].rad;
			nxt[k].side = cur[k].side;
			nxt[k].rem  = ge ? REM_W'(cand - trial) : cand[REM_W-1:0];
			nxt[k].root = {cur[k].root[NORM_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= (k == 0) ? in_v : v_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	assign out_v      = v_s[SQRT_STAGES-1];
	assign out_d.norm = stg_s[SQRT_STAGES-1].root;
	assign out_d.side = stg_s[SQRT_STAGES-1].side;

endmodule

// ----- rtl/core/spc_gap.sv -----
// gap, half gap, contact lever and status classification
module spc_gap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               cohesion,
	input  logic               in_v,
	input  spc_pkg::sqrt_out_t in_d,
	output logic               out_v,
	output spc_pkg::gap_out_t  out_d
);
	import spc_pkg::*;

	typedef struct packed {
		logic [NORM_W-1:0] norm;
		logic [34:0]       gap;
		side_t             side;
	} g1_t;

	typedef struct packed {
		logic [NORM_W-1:0] norm;
		logic [34:0]       gap;
		logic [34:0]       half;
		logic [32:0]       gmag;
		side_t             side;
	} g2_t;

	typedef struct packed {
		logic [NORM_W-1:0] norm;
		logic [34:0]       gap;
		logic [34:0]       t;
		logic [32:0]       gmag;
		status_t           status;
		side_t             side;
	} g3_t;

	logic     v_s1, v_s2, v_s3, v_s4;
	g1_t      g1_n, g1_s1;
	g2_t      g2_n, g2_s2;
	g3_t      g3_n, g3_s3;
	gap_out_t go_n, go_s4;
	logic     gpos;

	always_comb begin
		g1_n.norm = in_d.norm;
		g1_n.side = in_d.side;
		g1_n.gap  = {2'b00, in_d.norm} - {3'b000, in_d.side.rsum};
	end

	// half gap truncates toward zero
	always_comb begin
		g2_n.norm = g1_s1.norm;
		g2_n.gap  = g1_s1.gap;
		g2_n.side = g1_s1.side;
		g2_n.half = 35'($signed(g1_s1.gap + 35'(g1_s1.gap[34])) >>> 1);
		g2_n.gmag = g1_s1.gap[34] ? 33'(-g1_s1.gap) : g1_s1.gap[32:0];
	end

	always_comb begin
		gpos        = !g2_s2.gap[34] && (g2_s2.gap != '0);
		g3_n.norm   = g2_s2.norm;
		g3_n.gap    = g2_s2.gap;
		g3_n.gmag   = g2_s2.gmag;
		g3_n.side   = g2_s2.side;
		g3_n.t      = {4'b0000, g2_s2.side.ra} + g2_s2.half;
		if (gpos) begin
			g3_n.status = cohesion ? ST_COHESIVE : ST_NONE;
		end else if ({1'b0, g2_s2.side.ssum} <= g2_s2.gmag) begin
			g3_n.status = ST_TOO_DEEP;
		end else begin
			g3_n.status = ST_OVERLAP;
		end
	end

	always_comb begin
		go_n.norm   = g3_s3.norm;
		go_n.status = g3_s3.status;
		go_n.gap    = g3_s3.gap;
		go_n.gmag   = g3_s3.gmag;
		go_n.gneg   = g3_s3.gap[34];
		go_n.tneg   = g3_s3.t[34];
		go_n.tmag   = g3_s3.t[34] ? 33'(-g3_s3.t) : g3_s3.t[32:0];
		go_n.a      = g3_s3.side.a;
		go_n.dmag   = g3_s3.side.dmag;
		go_n.dneg   = g3_s3.side.dneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g1_s1 <= g1_n;
			g2_s2 <= g2_n;
			g3_s3 <= g3_n;
			go_s4 <= go_n;
		end
	end

	assign out_v = v_s4;
	assign out_d = go_s4;

endmodule

// ----- rtl/core/spc_div.sv -----
// three-lane restoring divider for the unit direction, one quotient bit per stage
module spc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  spc_pkg::gap_out_t in_d,
	output logic              out_v,
	output spc_pkg::div_out_t out_d
);
	import spc_pkg::*;

	typedef struct packed {
		gap_out_t               g;
		logic [2:0][NORM_W-1:0] rem;
		logic [2:0][QUO_W-1:0]  q;
	} dv_stage_t;

	logic [DIV_STAGES-1:0] v_s;
	dv_stage_t             stg_s [DIV_STAGES];
	dv_stage_t             cur   [DIV_STAGES];
	dv_stage_t             nxt   [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [2:0][NORM_W:0] cand;
		logic [2:0]           ge;

		if (j == 0) begin : g_first
			always_comb begin
				cur[j].g   = in_d;
				cur[j].rem = '0;
				cur[j].q   = '0;
			end
		end else begin : g_rest
			assign cur[j] = stg_s[j-1];
		end

		// the first stage sees |d| itself, later stages the doubled remainder
		always_comb begin
			nxt[j].g = cur[j].g;
			for (int i = 0; i < 3; i++) begin
				if (j == 0) begin
					cand[i] = {2'b00, cur[j].g.dmag[i]};
				end else begin
					cand[i] = {cur[j].rem[i], 1'b0};
				end
				ge[i]         = cand[i] >= {1'b0, cur[j].g.norm};
				nxt[j].rem[i] = ge[i] ? NORM_W'(cand[i] - {1'b0, cur[j].g.norm})
				                      : cand[i][NORM_W-1:0];
				nxt[j].q[i]   = {cur[j].q[i][QUO_W-2:0], ge[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= (j == 0) ? in_v : v_s[(j == 0) ? 0 : j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[j] <= nxt[j];
			end
		end
	end

	assign out_v   = v_s[DIV_STAGES-1];
	assign out_d.g = stg_s[DIV_STAGES-1].g;
	assign out_d.q = stg_s[DIV_STAGES-1].q;

endmodule

// ----- rtl/core/spc_back.sv -----
// scaling by the unit direction, contact point offset, saturation and masking
module spc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  spc_pkg::div_out_t in_d,
	output logic              out_v,
	output spc_pkg::contact_t out_d
);
	import spc_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [34:0]      gap;
		logic [2:0][31:0] a;
		logic [2:0][63:0] pov;
		logic [2:0][63:0] pct;
		logic [2:0]       ov_neg;
		logic [2:0]       ct_neg;
	} b1_t;

	typedef struct packed {
		status_t          status;
		logic [34:0]      gap;
		logic [2:0][31:0] a;
		logic [2:0][34:0] ov;
		logic [2:0][34:0] ct;
	} b2_t;

	logic                  v_s1, v_s2, v_s3;
	b1_t                   b1_n, b1_s1;
	b2_t                   b2_n, b2_s2;
	contact_t              ct_n, ct_s3;
	logic [2:0][QUO_W-1:0] qq;
	logic [2:0][33:0]      mov, mct;
	logic [2:0][35:0]      csum;
	logic                  keep;

	// coincident centers give a zero direction
	always_comb begin
		qq            = (in_d.g.norm == '0) ? '0 : in_d.q;
		b1_n.status   = in_d.g.status;
		b1_n.gap      = in_d.g.gap;
		b1_n.a        = in_d.g.a;
		for (int i = 0; i < 3; i++) begin
			b1_n.pov[i]    = {31'd0, in_d.g.gmag} * {33'd0, qq[i]};
			b1_n.pct[i]    = {31'd0, in_d.g.tmag} * {33'd0, qq[i]};
			b1_n.ov_neg[i] = in_d.g.gneg ^ in_d.g.dneg[i];
			b1_n.ct_neg[i] = in_d.g.tneg ^ in_d.g.dneg[i];
		end
	end

	always_comb begin
		b2_n.status = b1_s1.status;
		b2_n.gap    = b1_s1.gap;
		b2_n.a      = b1_s1.a;
		for (int i = 0; i < 3; i++) begin
			mov[i]     = b1_s1.pov[i][63:U_SHIFT];
			mct[i]     = b1_s1.pct[i][63:U_SHIFT];
			b2_n.ov[i] = b1_s1.ov_neg[i] ? 35'(-{1'b0, mov[i]}) : {1'b0, mov[i]};
			b2_n.ct[i] = b1_s1.ct_neg[i] ? 35'(-{1'b0, mct[i]}) : {1'b0, mct[i]};
		end
	end

	always_comb begin
		keep = (b2_s2.status == ST_OVERLAP) || (b2_s2.status == ST_COHESIVE);
		for (int i = 0; i < 3; i++) begin
			csum[i] = {{4{b2_s2.a[i][31]}}, b2_s2.a[i]} + {b2_s2.ct[i][34], b2_s2.ct[i]};
		end
		ct_n.status    = b2_s2.status;
		ct_n.gap       = keep ? sat32({b2_s2.gap[34], b2_s2.gap}) : '0;
		ct_n.overlap_x = keep ? sat32({b2_s2.ov[0][34], b2_s2.ov[0]}) : '0;
		ct_n.overlap_y = keep ? sat32({b2_s2.ov[1][34], b2_s2.ov[1]}) : '0;
		ct_n.overlap_z = keep ? sat32({b2_s2.ov[2][34], b2_s2.ov[2]}) : '0;
		ct_n.contact_x = keep ? sat32(csum[0]) : '0;
		ct_n.contact_y = keep ? sat32(csum[1]) : '0;
		ct_n.contact_z = keep ? sat32(csum[2]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b1_s1 <= b1_n;
			b2_s2 <= b2_n;
			ct_s3 <= ct_n;
		end
	end

	assign out_v = v_s3;
	assign out_d = ct_s3;

endmodule

// ----- test/sphere_pair_contact_checker.sv -----
// checker for the sphere pair contact core: predicts each contact beat and compares it
`timescale 1ns / 1ps
module sphere_pair_contact_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic              cfg_wdata,
	input  logic              pair_valid,
	input  logic              pair_ready,
	input  spc_pkg::pair_t    pair,
	input  logic              contact_valid,
	input  logic              contact_ready,
	input  spc_pkg::contact_t contact,
	output int                fail_count,
	output int                pending
);
	import spc_pkg::*;

	contact_t expected_contacts[$];
	logic cohesion_mode;

	// clamp to the signed 32-bit range
	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// (t * u) >> 30 with truncation toward zero, |t| < 2^35, |u| <= 2^30
	function automatic longint scale_unit(input longint t, input longint u);
		logic [127:0] p;
		longint m;
		p = (t < 0 ? -t : t) * (u < 0 ? -u : u);
		m = longint'(p >> 30);
		return ((t < 0) != (u < 0)) ? -m : m;
	endfunction

	function automatic contact_t predict_contact(input pair_t p, input logic coh);
		contact_t r;
		longint a[3], d[3], u[3];
		logic [127:0] sumsq, cand;
		longint root, gap, half, t, gmag;
		longint ra, rb, sa, sb;
		r = '0;
		a[0] = p.center_a_x; a[1] = p.center_a_y; a[2] = p.center_a_z;
		d[0] = longint'(p.center_b_x) - a[0];
		d[1] = longint'(p.center_b_y) - a[1];
		d[2] = longint'(p.center_b_z) - a[2];
		ra = p.radius_a; rb = p.radius_b; sa = p.shell_a; sb = p.shell_b;
		sumsq = 0;
		for (int i = 0; i < 3; i++)
			sumsq += 128'(d[i] < 0 ? -d[i] : d[i]) * 128'(d[i] < 0 ? -d[i] : d[i]);
		// bitwise integer square root, one root bit per step
		root = 0;
		for (int b = 33; b >= 0; b--) begin
			cand = 128'(root | (64'd1 << b));
			if (cand * cand <= sumsq) root = root | (64'd1 << b);
		end
		gap = root - (ra + rb);
		if (gap > 0) begin
			if (!coh) return r;
			r.status = ST_COHESIVE;
		end else begin
			gmag = -gap;
			if (gmag >= sa + sb) begin
				r.status = ST_TOO_DEEP;
				return r;
			end
			r.status = ST_OVERLAP;
		end
		for (int i = 0; i < 3; i++) begin
			if (root == 0) u[i] = 0;
			else begin
				u[i] = ((d[i] < 0 ? -d[i] : d[i]) <<< 30) / root;
				if (d[i] < 0) u[i] = -u[i];
			end
		end
		half = gap < 0 ? -((-gap) >>> 1) : (gap >>> 1);
		t = ra + half;
		r.gap = clamp32(gap);
		r.overlap_x = clamp32(scale_unit(gap, u[0]));
		r.overlap_y = clamp32(scale_unit(gap, u[1]));
		r.overlap_z = clamp32(scale_unit(gap, u[2]));
		r.contact_x = clamp32(a[0] + scale_unit(t, u[0]));
		r.contact_y = clamp32(a[1] + scale_unit(t, u[1]));
		r.contact_z = clamp32(a[2] + scale_unit(t, u[2]));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_contacts.size();

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		contact_t e;
		if (!arst_n) begin
			cohesion_mode <= 1'b0;
		end else begin
			if (cfg_wen) cohesion_mode <= cfg_wdata;
			if (pair_valid && pair_ready)
				expected_contacts.push_back(predict_contact(pair, cohesion_mode));
			if (contact_valid && contact_ready) begin
				if (expected_contacts.size() == 0) begin
					report_mismatch("unexpected beat", 32'(contact.status), 0);
				end else begin
					e = expected_contacts.pop_front();
					if (contact.status != e.status)
						report_mismatch("status", 32'(contact.status), 32'(e.status));
					if (contact.gap != e.gap) report_mismatch("gap", contact.gap, e.gap);
					if (contact.overlap_x != e.overlap_x)
						report_mismatch("overlap_x", contact.overlap_x, e.overlap_x);
					if (contact.overlap_y != e.overlap_y)
						report_mismatch("overlap_y", contact.overlap_y, e.overlap_y);
					if (contact.overlap_z != e.overlap_z)
						report_mismatch("overlap_z", contact.overlap_z, e.overlap_z);
					if (contact.contact_x != e.contact_x)
						report_mismatch("contact_x", contact.contact_x, e.contact_x);
					if (contact.contact_y != e.contact_y)
						report_mismatch("contact_y", contact.contact_y, e.contact_y);
					if (contact.contact_z != e.contact_z)
						report_mismatch("contact_z", contact.contact_z, e.contact_z);
				end
			end
		end
	end
endmodule

// ----- test/sphere_pair_contact_core_tb.sv -----
// testbench top for the sphere pair contact core: stimulus, stalls and verdict
`timescale 1ns / 1ps
module sphere_pair_contact_core_tb;
	import spc_pkg::*;

	localparam int PIPE_DEPTH = 80;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic cfg_wen, cfg_wdata;
	logic pair_valid, pair_ready;
	pair_t pair;
	logic contact_valid, contact_ready;
	contact_t contact;
	int fail_count, pending;
	longint cycle_count;
	// receiver control: random stalls, a long hold-off, then none
	bit quiet_tail, long_hold;

	sphere_pair_contact_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
		.contact_valid(contact_valid), .contact_ready(contact_ready), .contact(contact)
	);

	sphere_pair_contact_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
		.contact_valid(contact_valid), .contact_ready(contact_ready), .contact(contact),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: bursts of stall, long hold-off on request, always ready at the end
	initial begin
		contact_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				contact_ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 0;
				contact_ready <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				contact_ready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(posedge clk);
			end else begin
				contact_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic logic [30:0] pick_len();
		case ($urandom_range(0, 4))
			0: return 31'($urandom);
			1: return 31'h7fff_ffff;
			default: return 31'($urandom_range(0, 32'h0080_0000));
		endcase
	endfunction

	// random pair, mostly spheres near each other so contact and overlap are common
	function automatic pair_t random_pair();
		pair_t p;
		p.center_a_x = pick_coord(); p.center_a_y = pick_coord();
		p.center_a_z = pick_coord();
		p.radius_a = pick_len(); p.radius_b = pick_len();
		p.shell_a = pick_len(); p.shell_b = pick_len();
		if ($urandom_range(0, 3) != 0) begin
			p.center_b_x = p.center_a_x + ($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
			p.center_b_y = p.center_a_y + ($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
			p.center_b_z = p.center_a_z + ($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
		end else begin
			p.center_b_x = pick_coord(); p.center_b_y = pick_coord();
			p.center_b_z = pick_coord();
		end
		return p;
	endfunction

	function automatic pair_t make_pair(input logic signed [31:0] ax, ay, az, bx, by, bz,
			input logic [30:0] ra, rb, sa, sb);
		pair_t p;
		p.center_a_x = ax; p.center_a_y = ay; p.center_a_z = az;
		p.center_b_x = bx; p.center_b_y = by; p.center_b_z = bz;
		p.radius_a = ra; p.radius_b = rb; p.shell_a = sa; p.shell_b = sb;
		return p;
	endfunction

	// offer one beat; random gap first when gaps is set
	task automatic send_pair(input pair_t p, input bit gaps);
		if (gaps && $urandom_range(0, 4) == 0) begin
			pair_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (!pair_ready) @(posedge clk);
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_cohesion(input logic v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	localparam logic [30:0] ONE = 31'h0001_0000;

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 1'b0;
		pair_valid = 1'b0;
		pair = '0;
		quiet_tail = 0;
		long_hold = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both cohesion settings over the special cases
		for (int c = 0; c < 2; c++) begin
			write_cohesion(c[0]);
			// coincident centres, too deep with the shells just equal to the depth
			send_pair(make_pair(0, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE), 0);
			// coincident centres, too deep
			send_pair(make_pair(5, 6, 7, 5, 6, 7, ONE, ONE, 0, 0), 0);
			// touching along x
			send_pair(make_pair(0, 0, 0, 32'sh0002_0000, 0, 0, ONE, ONE, 0, 1), 0);
			// separated
			send_pair(make_pair(0, 0, 0, 0, 32'sh0010_0000, 0, ONE, ONE, ONE, ONE), 0);
			// negative direction, partial overlap
			send_pair(make_pair(0, 0, 0, 0, 0, -32'sh0001_8000, ONE, ONE, ONE, ONE), 0);
			// extreme corners, distance beyond 32 bits
			send_pair(make_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
				32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0), 0);
			send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
				32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
				31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff), 0);
			// huge radii, deep overlap with shells at max
			send_pair(make_pair(32'sh7fff_ffff, 0, 32'sh8000_0000, 32'sh7fff_fff0, 3, 32'sh8000_0001,
				31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff), 0);
			// centre a at all ones, centre b at zero, maximal radii and one maximal shell
			send_pair(make_pair(-1, -1, -1, 0, 0, 0,
				31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 0), 0);
			drain();
		end

		// random phases with changing cohesion setting
		for (int ph = 0; ph < 4; ph++) begin
			write_cohesion(ph[0]);
			for (int i = 0; i < 150; i++) send_pair(random_pair(), 1);
			if (ph == 1) begin
				// hold the output off while pairs keep arriving, so the input stalls
				long_hold = 1;
				for (int i = 0; i < 100; i++) send_pair(random_pair(), 0);
			end
			drain();
		end

		// quiet tail, no idling on either side
		quiet_tail = 1;
		for (int i = 0; i < 50; i++) send_pair(random_pair(), 0);
		drain();

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
